// ===== sv/assert_macros.svh =====
// assertion macros used by the rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define CHECK_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/pce_pkg.sv =====
// constants and codes of the correlation engine
`timescale 1ns / 1ps
`default_nettype none
package pce_pkg;
  localparam int MAX_PAIRS   = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_W     = 13;
  localparam int SUM_W       = 29;
  localparam int SQ_W        = 42;
  localparam int XY_W        = 43;
  localparam int DIFF_W      = 60;
  localparam int P_W         = 110;
  localparam int ACC_W       = 140;
  localparam int R_W         = 15;
  localparam int R_ONE       = 16384;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FEW      = 2'd1;
  localparam logic [1:0] ST_ZERO_VAR = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;
endpackage
`default_nettype wire

// ===== sv/pearson_correlation_engine_unit.sv =====
// Pearson correlation engine: one shift-add multiplier under a small sequencer.
// Each request carries one pair of Q3.12 samples; s_tlast marks the last pair of a set,
// and that request yields one result with r in Q1.14, a status code and the pair count.
// For each pair, three products |x|^2, |y|^2, |x*y| go through the shared multiplier,
// which retires one multiplier bit per cycle. The last pair adds the final pass: eight
// wide products and a binary search on r of up to 15 steps, each step two products.
// s_tready is high only while the sequencer waits for a pair; a finished result sits in
// the output register while the next pair is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pearson_correlation_engine_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // sample_x [15:0], sample_y [31:16]
  input  wire logic        s_tlast,   // last_pair
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // correlation [15:0], status [17:16], pair_count [30:18]
);
  import pce_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_XX, S_YY, S_XY, S_FIN, S_NXX, S_SX2, S_NYY, S_SY2,
    S_NXY, S_SXY, S_P, S_Q, S_LOOP, S_D2, S_K
  } state_t;

  state_t state;
  state_t after_out;
  logic out_pending;

  // accumulators
  logic [COUNT_W-1:0]      count;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic [SQ_W-1:0]         sum_xx, sum_yy;
  logic signed [XY_W-1:0]  sum_xy;
  logic                    overflow_seen;
  logic                    last_item;

  // latched pair
  logic [16:0] mag_x, mag_y;
  logic        xy_neg;

  // shared shift-add multiplier
  logic [ACC_W-1:0]  ma, macc;
  logic [DIFF_W-1:0] mb;

  // final pass values
  logic signed [DIFF_W-1:0] t1, sxx, syy, sxy;
  logic [P_W-1:0] p, q;
  logic [R_W-1:0] lo, hi, mid;

  // result register
  logic [15:0] res_corr;
  logic [1:0]  res_status;

  // input decode
  logic signed [SAMPLE_BITS-1:0] in_x, in_y;
  logic [16:0] mag_in_x, mag_in_y;
  assign in_x = s_tdata[15:0];
  assign in_y = s_tdata[31:16];
  assign mag_in_x = in_x[15] ? (17'd0 - {in_x[15], in_x}) : {1'b0, in_x};
  assign mag_in_y = in_y[15] ? (17'd0 - {in_y[15], in_y}) : {1'b0, in_y};

  // magnitudes and signed terms of the final pass
  logic [SUM_W-1:0]         mag_sx, mag_sy;
  logic [XY_W-1:0]          mag_sxy_acc;
  logic [DIFF_W-1:0]        mag_sxy, prod60;
  logic signed [DIFF_W-1:0] nxy_s, sxsy_s, sxy_next;
  logic signed [XY_W-1:0]   pxy;
  logic [R_W:0]             mid_sum;
  logic [R_W-1:0]           mid_next;
  logic [R_W-1:0]           d_next;
  assign mag_sx      = sum_x[SUM_W-1] ? ({SUM_W{1'b0}} - sum_x) : sum_x;
  assign mag_sy      = sum_y[SUM_W-1] ? ({SUM_W{1'b0}} - sum_y) : sum_y;
  assign mag_sxy_acc = sum_xy[XY_W-1] ? ({XY_W{1'b0}} - sum_xy) : sum_xy;
  assign mag_sxy     = sxy[DIFF_W-1] ? ({DIFF_W{1'b0}} - sxy) : sxy;
  assign prod60      = macc[DIFF_W-1:0];
  assign nxy_s       = sum_xy[XY_W-1] ? ({DIFF_W{1'b0}} - prod60) : prod60;
  assign sxsy_s      = (sum_x[SUM_W-1] ^ sum_y[SUM_W-1]) ? ({DIFF_W{1'b0}} - prod60) : prod60;
  assign sxy_next    = t1 - sxsy_s;
  assign pxy         = {{(XY_W-31){1'b0}}, macc[30:0]};
  assign mid_sum     = {1'b0, lo} + {1'b0, hi} + {{R_W{1'b0}}, 1'b1};
  assign mid_next    = mid_sum[R_W:1];
  assign d_next      = {mid_next[R_W-2:0], 1'b0} - {{(R_W-1){1'b0}}, 1'b1};

  assign s_tready = (state == S_IDLE) && !out_pending;

  // sequencer, multiplier and result register
  always_ff @(posedge clk) begin
    // multiplier step: one bit of the multiplier per cycle
    if (!rst && mb != '0) begin
      if (mb[0]) begin
        macc <= macc + ma;
      end
      ma <= {ma[ACC_W-2:0], 1'b0};
      mb <= {1'b0, mb[DIFF_W-1:1]};
    end
    if (m_tvalid && m_tready && !rst && !out_pending) begin
      m_tvalid <= 1'b0;
    end
    if (rst) begin
      state         <= S_IDLE;
      after_out     <= S_IDLE;
      out_pending   <= 1'b0;
      m_tvalid      <= 1'b0;
      count         <= '0;
      sum_x         <= '0;
      sum_y         <= '0;
      sum_xx        <= '0;
      sum_yy        <= '0;
      sum_xy        <= '0;
      overflow_seen <= 1'b0;
      last_item     <= 1'b0;
      mb            <= '0;
    end else if (out_pending) begin
      // hand the result to the output register, then clear the sums
      if (!m_tvalid || m_tready) begin
        m_tvalid      <= 1'b1;
        m_tdata       <= {1'b0, count, res_status, res_corr};
        out_pending   <= 1'b0;
        count         <= '0;
        sum_x         <= '0;
        sum_y         <= '0;
        sum_xx        <= '0;
        sum_yy        <= '0;
        sum_xy        <= '0;
        overflow_seen <= 1'b0;
        state         <= after_out;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            last_item <= s_tlast;
            if (count < COUNT_W'(MAX_PAIRS)) begin
              count  <= count + 1'b1;
              sum_x  <= sum_x + SUM_W'(in_x);
              sum_y  <= sum_y + SUM_W'(in_y);
              mag_x  <= mag_in_x;
              mag_y  <= mag_in_y;
              xy_neg <= in_x[15] ^ in_y[15];
              ma     <= ACC_W'(mag_in_x);
              mb     <= DIFF_W'(mag_in_x);
              macc   <= '0;
              state  <= S_XX;
            end else begin
              overflow_seen <= 1'b1;
              if (s_tlast) begin
                state <= S_FIN;
              end
            end
          end
        end
        S_XX: begin
          if (mb == '0) begin
            sum_xx <= sum_xx + SQ_W'(macc[30:0]);
            ma     <= ACC_W'(mag_y);
            mb     <= DIFF_W'(mag_y);
            macc   <= '0;
            state  <= S_YY;
          end
        end
        S_YY: begin
          if (mb == '0) begin
            sum_yy <= sum_yy + SQ_W'(macc[30:0]);
            ma     <= ACC_W'(mag_x);
            mb     <= DIFF_W'(mag_y);
            macc   <= '0;
            state  <= S_XY;
          end
        end
        S_XY: begin
          if (mb == '0) begin
            sum_xy <= xy_neg ? (sum_xy - pxy) : (sum_xy + pxy);
            state  <= last_item ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          if (count < COUNT_W'(2)) begin
            res_corr    <= '0;
            res_status  <= ST_FEW;
            out_pending <= 1'b1;
            after_out   <= S_IDLE;
          end else begin
            ma    <= ACC_W'(sum_xx);
            mb    <= DIFF_W'(count);
            macc  <= '0;
            state <= S_NXX;
          end
        end
        S_NXX: begin
          if (mb == '0) begin
            t1    <= prod60;
            ma    <= ACC_W'(mag_sx);
            mb    <= DIFF_W'(mag_sx);
            macc  <= '0;
            state <= S_SX2;
          end
        end
        S_SX2: begin
          if (mb == '0) begin
            sxx   <= t1 - $signed(prod60);
            ma    <= ACC_W'(sum_yy);
            mb    <= DIFF_W'(count);
            macc  <= '0;
            state <= S_NYY;
          end
        end
        S_NYY: begin
          if (mb == '0) begin
            t1    <= prod60;
            ma    <= ACC_W'(mag_sy);
            mb    <= DIFF_W'(mag_sy);
            macc  <= '0;
            state <= S_SY2;
          end
        end
        S_SY2: begin
          if (mb == '0) begin
            syy   <= t1 - $signed(prod60);
            ma    <= ACC_W'(mag_sxy_acc);
            mb    <= DIFF_W'(count);
            macc  <= '0;
            state <= S_NXY;
          end
        end
        S_NXY: begin
          if (mb == '0) begin
            t1    <= nxy_s;
            ma    <= ACC_W'(mag_sx);
            mb    <= DIFF_W'(mag_sy);
            macc  <= '0;
            state <= S_SXY;
          end
        end
        S_SXY: begin
          if (mb == '0) begin
            sxy <= sxy_next;
            if (sxx <= 0 || syy <= 0) begin
              res_corr    <= '0;
              res_status  <= ST_ZERO_VAR;
              out_pending <= 1'b1;
              after_out   <= S_IDLE;
            end else begin
              ma    <= ACC_W'(sxx);
              mb    <= syy;
              macc  <= '0;
              state <= S_P;
            end
          end
        end
        S_P: begin
          if (mb == '0) begin
            p     <= macc[P_W-1:0];
            ma    <= ACC_W'(mag_sxy);
            mb    <= mag_sxy;
            macc  <= '0;
            lo    <= '0;
            hi    <= R_W'(R_ONE);
            state <= S_Q;
          end
        end
        S_Q: begin
          if (mb == '0) begin
            q     <= macc[P_W-1:0];
            state <= S_LOOP;
          end
        end
        // binary search: largest m with (2m-1)^2 * p <= q * 2^30
        S_LOOP: begin
          if (lo < hi) begin
            mid   <= mid_next;
            ma    <= ACC_W'(d_next);
            mb    <= DIFF_W'(d_next);
            macc  <= '0;
            state <= S_D2;
          end else begin
            res_corr    <= sxy[DIFF_W-1] ? (16'd0 - {1'b0, lo}) : {1'b0, lo};
            res_status  <= overflow_seen ? ST_OVERFLOW : ST_OK;
            out_pending <= 1'b1;
            after_out   <= S_IDLE;
          end
        end
        S_D2: begin
          if (mb == '0) begin
            ma    <= ACC_W'(p);
            mb    <= DIFF_W'(macc[29:0]);
            macc  <= '0;
            state <= S_K;
          end
        end
        S_K: begin
          if (mb == '0) begin
            if (macc <= {q, 30'd0}) begin
              lo <= mid;
            end else begin
              hi <= mid - 1'b1;
            end
            state <= S_LOOP;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHECK_ALWAYS(a_count_bound, count <= COUNT_W'(MAX_PAIRS), "pair count beyond store")
  `CHECK_IMPLIES(a_search_order, state == S_LOOP, lo <= hi, "search bounds crossed")
  `CHECK_IMPLIES(a_corr_range, m_tvalid, ($signed(m_tdata[15:0]) <= 16'sd16384) && ($signed(m_tdata[15:0]) >= -16'sd16384), "correlation out of range")
  `CHECK_IMPLIES(a_zero_var_corr, m_tvalid && (m_tdata[17:16] == ST_ZERO_VAR || m_tdata[17:16] == ST_FEW), m_tdata[15:0] == 16'd0, "degenerate set with nonzero r")
  `CHECK_IMPLIES(a_busy_not_ready, state != S_IDLE, !s_tready, "ready while sequencer busy")

endmodule
`default_nettype wire

// ===== tb/sv/pearson_correlation_engine_unit_tb.sv =====
// self-checking testbench for the streaming pearson correlation engine
`timescale 1ns / 1ps
`default_nettype none
module pearson_correlation_engine_unit_tb;
  import pce_pkg::*;

  typedef struct packed {
    logic signed [15:0] corr;
    logic [1:0]         status;
    logic [12:0]        count;
  } corr_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // sample_x [15:0], sample_y [31:16]
  logic        s_tlast;   // last_pair
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // correlation [15:0], status [17:16], pair_count [30:18]

  // running sums of the set being accumulated
  longint      pair_cnt;
  longint      sx, sy, sxx_sum, syy_sum, sxy_sum;
  bit          store_full;

  corr_result_t pending_results[$];
  int          fail_cnt;
  int          sent_pairs;
  int          hold_req;
  bit          no_gaps;

  pearson_correlation_engine_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void clear_sums();
    pair_cnt = 0; sx = 0; sy = 0; sxx_sum = 0; syy_sum = 0; sxy_sum = 0;
    store_full = 1'b0;
  endfunction

  // exact rounded magnitude of 16384*|sxy|/sqrt(sxx*syy) by binary search
  function automatic int corr_magnitude(longint vx, longint vy, longint cxy);
    logic [191:0] prod_var, lhs, rhs, d;
    longint       mag_xy;
    int           lo, hi, mid;
    mag_xy   = (cxy < 0) ? -cxy : cxy;
    prod_var = 192'(vx) * 192'(vy);
    rhs      = (192'(mag_xy) * 192'(mag_xy)) << 30;
    lo = 0;
    hi = R_ONE;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      d   = 192'(2 * mid - 1);
      lhs = d * d * prod_var;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // accumulate one pair and queue the result that a last pair causes
  function automatic void predict_pair(logic signed [15:0] x, logic signed [15:0] y,
                                       logic last);
    corr_result_t res;
    longint       vx, vy, cxy;
    int           m;
    if (pair_cnt < MAX_PAIRS) begin
      pair_cnt++;
      sx += x; sy += y;
      sxx_sum += longint'(x) * x;
      syy_sum += longint'(y) * y;
      sxy_sum += longint'(x) * y;
    end else begin
      store_full = 1'b1;
    end
    if (!last) return;
    res.corr  = '0;
    res.count = pair_cnt[12:0];
    if (pair_cnt < 2) begin
      res.status = ST_FEW;
    end else begin
      vx  = pair_cnt * sxx_sum - sx * sx;
      vy  = pair_cnt * syy_sum - sy * sy;
      cxy = pair_cnt * sxy_sum - sx * sy;
      if (vx <= 0 || vy <= 0) begin
        res.status = ST_ZERO_VAR;
      end else begin
        m = corr_magnitude(vx, vy, cxy);
        res.corr   = (cxy < 0) ? -16'(m) : 16'(m);
        res.status = store_full ? ST_OVERFLOW : ST_OK;
      end
    end
    pending_results.push_back(res);
    clear_sums();
  endfunction

  // offer one pair and wait until it is taken
  task automatic send_pair(logic signed [15:0] x, logic signed [15:0] y, logic last);
    int gap;
    bit rdy;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    s_tlast  <= last;
    do begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
    end while (!rdy);
    predict_pair(x, y, last);
    sent_pairs++;
  endtask

  task automatic idle_input();
    s_tvalid <= 1'b0;
  endtask

  // wait for every queued result, then the final pass latency
  task automatic drain_results();
    idle_input();
    wait (pending_results.size() == 0);
    repeat (1300) @(posedge clk);
  endtask

  // result side: random stalls plus requested long hold-off
  initial begin : result_side
    corr_result_t exp_r, got;
    bit ok;
    int stall;
    stall = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      ok  = m_tvalid && m_tready && !rst;
      got = {m_tdata[15:0], m_tdata[17:16], m_tdata[30:18]};
      @(posedge clk);
      if (ok) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, got);
          fail_cnt++;
        end else begin
          exp_r = pending_results.pop_front();
          if (got.corr !== exp_r.corr) begin
            $display("%0t: correlation expected %0d actual %0d", $realtime,
                     exp_r.corr, got.corr);
            fail_cnt++;
          end
          if (got.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime,
                     exp_r.status, got.status);
            fail_cnt++;
          end
          if (got.count !== exp_r.count) begin
            $display("%0t: pair_count expected %0d actual %0d", $realtime,
                     exp_r.count, got.count);
            fail_cnt++;
          end
        end
      end
      if (hold_req > 0) begin
        hold_req--;
        m_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        stall = pick_gap();
        m_tready <= (stall == 0);
      end
    end
  end

  // extremes of both samples and both signs of r
  task automatic test_extremes();
    send_pair(16'sh8000, 16'sh7fff, 1'b0);
    send_pair(16'sh7fff, 16'sh8000, 1'b1);
    send_pair(16'sh8000, 16'sh8000, 1'b0);
    send_pair(16'sh7fff, 16'sh7fff, 1'b1);
    send_pair(16'sh0001, 16'shffff, 1'b0);
    send_pair(16'sh5555, 16'shaaaa, 1'b0);
    send_pair(16'shaaaa, 16'sh5555, 1'b1);
    send_pair(16'sh1000, 16'sh0800, 1'b0);
    send_pair(16'sh2000, 16'sh0200, 1'b0);
    send_pair(16'sh0000, 16'sh0f00, 1'b1);
  endtask

  // single pair sets
  task automatic test_few_pairs();
    send_pair(16'sh7fff, 16'sh8000, 1'b1);
    send_pair(16'sh0000, 16'sh0000, 1'b1);
  endtask

  // constant x, then constant y
  task automatic test_zero_variance();
    send_pair(16'sh1234, 16'sh0001, 1'b0);
    send_pair(16'sh1234, 16'sh7000, 1'b0);
    send_pair(16'sh1234, 16'sh9000, 1'b1);
    send_pair(16'sh0100, 16'sh8000, 1'b0);
    send_pair(16'sh7f00, 16'sh8000, 1'b1);
  endtask

  // store filled to the last entry, then pairs beyond it
  task automatic test_overflow();
    no_gaps = 1'b1;
    for (int i = 0; i < MAX_PAIRS + 2; i++)
      send_pair(16'($urandom), 16'($urandom), i == MAX_PAIRS + 1);
    no_gaps = 1'b0;
  endtask

  // long result hold-off while short sets keep coming
  task automatic test_backpressure();
    drain_results();
    hold_req = 4000;
    for (int i = 0; i < 24; i++)
      send_pair(16'($urandom), 16'($urandom), i[0]);
    drain_results();
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // random sets, mostly short, with correlated and constant content
  task automatic test_random();
    int len, kind, start;
    logic [15:0] x, y, cx;
    start = sent_pairs;
    while (sent_pairs - start < 1000) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      kind = $urandom_range(0, 5);
      cx   = rand_sample();
      for (int i = 0; i < len; i++) begin
        x = (kind == 4) ? cx : rand_sample();
        case (kind)
          0: y = x + 16'($urandom_range(0, 255));
          1: y = -x + 16'($urandom_range(0, 63));
          2: y = x;
          default: y = rand_sample();
        endcase
        send_pair(x, y, i == len - 1);
      end
      if ($urandom_range(0, 29) == 0) drain_results();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    fail_cnt   = 0;
    sent_pairs = 0;
    hold_req   = 0;
    no_gaps    = 1'b0;
    clear_sums();
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_few_pairs();
    test_zero_variance();
    test_backpressure();
    test_overflow();
    test_random();
    drain_results();
    if (fail_cnt == 0) begin
      $display("pearson_correlation_engine_unit_tb: PASS");
    end else begin
      $display("pearson_correlation_engine_unit_tb: FAIL");
    end
    $finish;
  end

  // watchdog on the whole run
  initial begin
    #100ms;
    $display("pearson_correlation_engine_unit_tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
